[sv/lpg_pkg.sv]
package lpg_pkg;

    // Coordinate width used when endpoints are sign-extended
    localparam int COORD_BITS  = 16;
    localparam int COORD_SHIFT = 16 - COORD_BITS;

    // Operation codes
    localparam logic OP_START = 1'b0;
    localparam logic OP_STEP  = 1'b1;

    // Register indexes
    localparam logic [1:0] CFG_CLIP_X = 2'd0;
    localparam logic [1:0] CFG_CLIP_Y = 2'd1;
    localparam logic [1:0] CFG_CLIP_W = 2'd2;
    localparam logic [1:0] CFG_CLIP_H = 2'd3;

    localparam logic [14:0] CLIP_W_RESET = 15'h7FFF;
    localparam logic [14:0] CLIP_H_RESET = 15'h7FFF;

    typedef enum logic [3:0] {
        MODE_IDLE = 4'b0001,
        MODE_HORZ = 4'b0010,
        MODE_VERT = 4'b0100,
        MODE_DIAG = 4'b1000
    } t_mode;

    typedef struct packed {
        logic               operation;
        logic signed [15:0] x_start;
        logic signed [15:0] y_start;
        logic signed [15:0] x_end;
        logic signed [15:0] y_end;
        logic [31:0]        line_color;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0] pixel_x;
        logic signed [15:0] pixel_y;
        logic [31:0]        pixel_color;
        logic               blend_needed;
        logic               last_pixel;
    } t_out_item;

    // Line state loaded by a start item
    typedef struct packed {
        t_mode              mode;
        logic [15:0]        cur_x;
        logic [15:0]        cur_y;
        logic [16:0]        left;
        logic signed [18:0] err;
        logic [17:0]        twice_dx;
        logic [17:0]        twice_dy;
        logic               sx_neg;
        logic               sy_neg;
        logic               x_major;
        logic [31:0]        color;
        logic               blend;
    } t_setup;

    // Status of the line walker
    typedef struct packed {
        logic busy;
        logic res_valid;
    } t_core_status;

    function automatic logic signed [15:0] sext_coord(logic signed [15:0] v);
        logic signed [15:0] t;
        t = v <<< COORD_SHIFT;
        return t >>> COORD_SHIFT;
    endfunction

endpackage

[sv/lpg_setup.sv]
module lpg_setup (
    input  lpg_pkg::t_in_item i_item,
    input  logic [14:0]       i_clip_x,
    input  logic [14:0]       i_clip_y,
    input  logic [15:0]       i_clip_right,
    input  logic [15:0]       i_clip_bottom,
    output lpg_pkg::t_setup   o_setup
);

    logic signed [15:0] x1, y1, x2, y2;
    logic signed [15:0] vy_lo, vy_hi;
    logic signed [16:0] v_len;
    logic signed [17:0] y18, top18, bot18, left18, right18;
    logic signed [17:0] hx_lo, hx_hi, hc_lo, hc_hi, h_len;
    logic               in_rows;
    logic signed [16:0] ddx, ddy;
    logic [16:0]        dx, dy;
    logic               x_major;

    assign x1 = lpg_pkg::sext_coord(i_item.x_start);
    assign y1 = lpg_pkg::sext_coord(i_item.y_start);
    assign x2 = lpg_pkg::sext_coord(i_item.x_end);
    assign y2 = lpg_pkg::sext_coord(i_item.y_end);

    // Vertical: sort ends
    assign vy_lo = (y1 < y2) ? y1 : y2;
    assign vy_hi = (y1 < y2) ? y2 : y1;
    assign v_len = 17'(vy_hi) - 17'(vy_lo);

    // Horizontal: row test, sort, clamp to clip columns
    assign y18     = 18'(y1);
    assign top18   = $signed({3'b000, i_clip_y});
    assign bot18   = $signed({2'b00, i_clip_bottom});
    assign left18  = $signed({3'b000, i_clip_x});
    assign right18 = $signed({2'b00, i_clip_right});
    assign in_rows = (y18 >= top18) && (y18 < bot18);
    assign hx_lo   = (x1 < x2) ? 18'(x1) : 18'(x2);
    assign hx_hi   = (x1 < x2) ? 18'(x2) : 18'(x1);
    assign hc_lo   = (hx_lo < left18) ? left18 : ((hx_lo > right18) ? right18 : hx_lo);
    assign hc_hi   = (hx_hi < left18) ? left18 : ((hx_hi > right18) ? right18 : hx_hi);
    assign h_len   = hc_hi - hc_lo;

    // General: deltas and major axis
    assign ddx     = 17'(x2) - 17'(x1);
    assign ddy     = 17'(y2) - 17'(y1);
    assign dx      = (ddx < 0) ? 17'(-ddx) : 17'(ddx);
    assign dy      = (ddy < 0) ? 17'(-ddy) : 17'(ddy);
    assign x_major = (dy <= dx);

    // Select the line kind
    always_comb begin
        o_setup          = '0;
        o_setup.mode     = lpg_pkg::MODE_IDLE;
        o_setup.color    = i_item.line_color;
        if (x1 == x2) begin
            o_setup.cur_x = x1;
            o_setup.cur_y = vy_lo;
            o_setup.left  = 17'(v_len);
            if (v_len != 0) begin
                o_setup.mode = lpg_pkg::MODE_VERT;
            end
        end else if (y1 == y2) begin
            o_setup.cur_y = y1;
            if (in_rows) begin
                o_setup.cur_x = hc_lo[15:0];
                o_setup.left  = h_len[16:0];
                o_setup.blend = (i_item.line_color[31:24] != 8'hFF);
                if (h_len != 0) begin
                    o_setup.mode = lpg_pkg::MODE_HORZ;
                end
            end
        end else begin
            o_setup.mode     = lpg_pkg::MODE_DIAG;
            o_setup.cur_x    = x1;
            o_setup.cur_y    = y1;
            o_setup.sx_neg   = !(x1 < x2);
            o_setup.sy_neg   = !(y1 < y2);
            o_setup.twice_dx = {dx, 1'b0};
            o_setup.twice_dy = {dy, 1'b0};
            o_setup.x_major  = x_major;
            if (x_major) begin
                o_setup.err  = -$signed({2'b00, dx});
                o_setup.left = dx + 17'd1;
            end else begin
                o_setup.err  = -$signed({2'b00, dy});
                o_setup.left = dy + 17'd1;
            end
        end
    end

endmodule

[sv/lpg_core.sv]
module lpg_core (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_go,
    input  logic                  i_op,
    input  lpg_pkg::t_setup       i_setup,
    output lpg_pkg::t_core_status o_status,
    output lpg_pkg::t_out_item    o_res
);

    lpg_pkg::t_setup r_st, n_st;
    logic            w_active;
    logic            w_emit;
    logic [15:0]     w_sx, w_sy;
    logic [17:0]     w_minor, w_major;
    logic signed [18:0] w_e1, w_e2;

    assign w_active = (r_st.mode != lpg_pkg::MODE_IDLE) && (r_st.left != 17'd0);
    assign w_emit   = i_go && (i_op == lpg_pkg::OP_STEP) && w_active;
    assign w_sx     = r_st.sx_neg ? 16'hFFFF : 16'h0001;
    assign w_sy     = r_st.sy_neg ? 16'hFFFF : 16'h0001;
    assign w_minor  = r_st.x_major ? r_st.twice_dy : r_st.twice_dx;
    assign w_major  = r_st.x_major ? r_st.twice_dx : r_st.twice_dy;

    // Error update: add minor, subtract major when the sum is not negative
    assign w_e1 = r_st.err + $signed({1'b0, w_minor});
    assign w_e2 = w_e1 - $signed({1'b0, w_major});

    // Load a new line or advance one pixel
    always_comb begin
        n_st = r_st;
        if (i_go) begin
            if (i_op == lpg_pkg::OP_START) begin
                n_st = i_setup;
            end else if (w_active) begin
                n_st.left = r_st.left - 17'd1;
                if (r_st.left == 17'd1) begin
                    n_st.mode = lpg_pkg::MODE_IDLE;
                end else begin
                    case (r_st.mode)
                        lpg_pkg::MODE_HORZ: begin
                            n_st.cur_x = r_st.cur_x + 16'd1;
                        end
                        lpg_pkg::MODE_VERT: begin
                            n_st.cur_y = r_st.cur_y + 16'd1;
                        end
                        lpg_pkg::MODE_DIAG: begin
                            if (r_st.x_major) begin
                                n_st.cur_x = r_st.cur_x + w_sx;
                                if (w_e1 >= 0) begin
                                    n_st.cur_y = r_st.cur_y + w_sy;
                                end
                            end else begin
                                n_st.cur_y = r_st.cur_y + w_sy;
                                if (w_e1 >= 0) begin
                                    n_st.cur_x = r_st.cur_x + w_sx;
                                end
                            end
                            n_st.err = (w_e1 >= 0) ? w_e2 : w_e1;
                        end
                        default: begin
                        end
                    endcase
                end
            end else begin
                n_st.mode = lpg_pkg::MODE_IDLE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= '{mode: lpg_pkg::MODE_IDLE, default: '0};
        end else begin
            r_st <= n_st;
        end
    end

    // Pixel taken from the current position
    assign o_res.pixel_x      = r_st.cur_x;
    assign o_res.pixel_y      = r_st.cur_y;
    assign o_res.pixel_color  = r_st.color;
    assign o_res.blend_needed = r_st.blend;
    assign o_res.last_pixel   = (r_st.left == 17'd1);

    assign o_status.busy      = (r_st.mode != lpg_pkg::MODE_IDLE);
    assign o_status.res_valid = w_emit;

endmodule

[sv/line_pixel_generator.sv]
// Channel  | Direction | Handshake                  | Payload
// input    | in        | i_in_valid / o_in_ready    | i_in_item  (lpg_pkg::t_in_item)
// output   | out       | o_out_valid / i_out_ready  | o_out_item (lpg_pkg::t_out_item)
// config   | in        | i_cfg_we (no wait)         | i_cfg_index, i_cfg_data
//
// One item per clock while the output register has room: an item waits in the
// input register, then the line walker handles it and a step writes its pixel
// into the output register, which then raises o_out_valid.
// An item is held in the input register while the output register is full
// and not being taken; the input register frees in the same cycle it drains.
// Synchronous active-low reset clears the valids and returns the walker to idle.
module line_pixel_generator (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  lpg_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output lpg_pkg::t_out_item o_out_item,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [14:0]        i_cfg_data
);

    logic [14:0]           r_clip_x, r_clip_y, r_clip_w, r_clip_h;
    logic [15:0]           w_clip_right, w_clip_bottom;
    logic                  r_in_valid, n_in_valid;
    lpg_pkg::t_in_item     r_in_item;
    logic                  r_out_valid, n_out_valid;
    lpg_pkg::t_out_item    r_out_item;
    logic                  w_process;
    lpg_pkg::t_setup       w_setup;
    lpg_pkg::t_core_status w_status;
    lpg_pkg::t_out_item    w_res;

    // Clip registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clip_x <= '0;
            r_clip_y <= '0;
            r_clip_w <= lpg_pkg::CLIP_W_RESET;
            r_clip_h <= lpg_pkg::CLIP_H_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                lpg_pkg::CFG_CLIP_X: r_clip_x <= i_cfg_data;
                lpg_pkg::CFG_CLIP_Y: r_clip_y <= i_cfg_data;
                lpg_pkg::CFG_CLIP_W: r_clip_w <= i_cfg_data;
                lpg_pkg::CFG_CLIP_H: r_clip_h <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Right and bottom clip edges, no wrap
    assign w_clip_right  = {1'b0, r_clip_x} + {1'b0, r_clip_w};
    assign w_clip_bottom = {1'b0, r_clip_y} + {1'b0, r_clip_h};

    // Drain the input register when the output register has room
    assign w_process  = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_process;

    always_comb begin
        n_in_valid = r_in_valid;
        if (w_process) begin
            n_in_valid = 1'b0;
        end
        if (i_in_valid && o_in_ready) begin
            n_in_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
    end

    // Capture an input transfer
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_item <= i_in_item;
        end
    end

    lpg_setup u_setup (
        .i_item        (r_in_item),
        .i_clip_x      (r_clip_x),
        .i_clip_y      (r_clip_y),
        .i_clip_right  (w_clip_right),
        .i_clip_bottom (w_clip_bottom),
        .o_setup       (w_setup)
    );

    lpg_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_go     (w_process),
        .i_op     (r_in_item.operation),
        .i_setup  (w_setup),
        .o_status (w_status),
        .o_res    (w_res)
    );

    // Output register: load a pixel, clear on transfer
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        if (w_status.res_valid) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_status.res_valid) begin
            r_out_item <= w_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

`ifndef SYNTH
    // A pixel is only produced when the output register can take it
    a_res_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_status.res_valid |-> (!r_out_valid || i_out_ready))
        else $error("pixel produced while output register is blocked");

    // A step never yields a pixel while the walker is idle
    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_status.busy |-> !w_status.res_valid)
        else $error("pixel produced with no line pending");

    // The last pixel returns the walker to idle
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_status.res_valid && w_res.last_pixel) |=> !w_status.busy)
        else $error("walker still busy after last pixel");

    // Nothing leaves right after reset
    a_reset_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");
`endif

endmodule
